/* hw/rtl/slcg_pkg.sv */
// Package for the shuffled Lehmer uniform generator.
// Holds shared constants, the request codes and the controller-to-datapath command type.
// No dependencies.
package slcg_pkg;

    // Default number of entries in the shuffle table.
    localparam int TABLE_DEPTH_DEF = 32;

    // Generator steps run after a seed load, before the table fill starts.
    localparam int WARMUP_STEPS = 8;

    // Lehmer multiplier and Mersenne prime modulus.
    localparam logic [14:0] LCG_MULT   = 15'd16807;
    localparam logic [30:0] LCG_MOD    = 31'h7FFF_FFFF;
    localparam logic [30:0] SAMPLE_MAX = 31'd2147483389;

    // Request codes carried on the op field of an input word.
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Commands from the controller to the datapath, one cycle each.
    typedef struct packed {
        logic load_seed;      // load the generator from a seed source
        logic seed_sel_input; // seed source is the input word, not the generator
        logic mul;            // register generator times multiplier
        logic fold;           // reduce the product modulo the prime into the generator
        logic seed_we;        // write the fold result into the table at the fill address
        logic seed_last;      // last fill step: fold result becomes the last output
        logic calc_idx;       // compute the table index from the last output
        logic draw_commit;    // finish a draw: swap the table entry and load the result
    } slcg_cmd_t;

endpackage

/* hw/rtl/slcg_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module slcg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/slcg_dpath.sv */
// Datapath of the shuffled Lehmer generator: generator register, modular
// multiply, index reciprocal multiply, shuffle table and result register.
// Depends on slcg_pkg and slcg_ram.
module slcg_dpath #(
    parameter int TABLE_DEPTH = slcg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  slcg_pkg::slcg_cmd_t            cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] seed_addr,
    input  logic [30:0]                    s_seed_value,
    output logic                           seeded,
    output logic [30:0]                    m_sample
);
    import slcg_pkg::*;

    // Index = last output / bucket, done as a multiply by a rounded-up
    // reciprocal. With the shift set to 31 plus the ceiling log2 of the bucket the
    // quotient is exact for every 31-bit operand.
    localparam longint unsigned MOD_L = 64'd2147483647;
    localparam longint unsigned BUCKET = 64'd1 + (MOD_L - 64'd1) / TABLE_DEPTH;
    localparam int BUCKET_LOG = $clog2(BUCKET);
    localparam int SHIFT = 31 + BUCKET_LOG;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + BUCKET - 64'd1) / BUCKET;
    localparam logic [31:0] RECIP_W = 32'(RECIP);
    localparam int QW = 63 - SHIFT;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] IDX_MAX = AW'(TABLE_DEPTH - 1);

    logic [30:0]   gen_reg;
    logic [45:0]   prod_reg;
    logic [30:0]   last_reg;
    logic [QW-1:0] idx_q_reg;
    logic [30:0]   sample_reg;

    logic [31:0]   fold_sum;
    logic [30:0]   fold_red;
    logic [30:0]   fold_x;
    logic [30:0]   seed_src;
    logic [30:0]   seed_fixed;
    logic [30:0]   idx_op;
    logic [62:0]   idx_prod;
    logic [AW-1:0] idx;
    logic [30:0]   table_rdata;
    logic          table_we;
    logic [AW-1:0] table_waddr;

    // Modular reduction of the registered product: fold the high bits onto
    // the low bits, one conditional subtract, and map zero to the modulus.
    always_comb begin
        fold_sum = {1'b0, prod_reg[30:0]} + 32'(prod_reg[45:31]);
        if (fold_sum >= {1'b0, LCG_MOD}) begin
            fold_red = 31'(fold_sum - {1'b0, LCG_MOD});
        end else begin
            fold_red = fold_sum[30:0];
        end
        fold_x = (fold_red == 31'd0) ? LCG_MOD : fold_red;
    end

    // Seed selection; zero and the modulus itself become one.
    always_comb begin
        seed_src = cmd.seed_sel_input ? s_seed_value : gen_reg;
        if (seed_src == 31'd0 || seed_src == LCG_MOD) begin
            seed_fixed = 31'd1;
        end else begin
            seed_fixed = seed_src;
        end
    end

    // Reciprocal multiply for the table index, from the picked entry on a
    // draw or from the last output at the end of a reseed.
    assign idx_op   = cmd.draw_commit ? table_rdata : last_reg;
    assign idx_prod = 63'(idx_op) * 63'(RECIP_W);

    // Clamp the quotient to the table.
    always_comb begin
        if (32'(idx_q_reg) >= 32'(TABLE_DEPTH)) begin
            idx = IDX_MAX;
        end else begin
            idx = AW'(idx_q_reg);
        end
    end

    // The last output doubles as the seeded flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg  <= 31'd1;
            last_reg <= 31'd0;
        end else begin
            if (cmd.load_seed) begin
                gen_reg <= seed_fixed;
            end else if (cmd.fold) begin
                gen_reg <= fold_x;
            end
            if (cmd.fold && cmd.seed_last) begin
                last_reg <= fold_x;
            end else if (cmd.draw_commit) begin
                last_reg <= table_rdata;
            end
        end
    end

    // Payload registers: product, index quotient and result word.
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= 46'(gen_reg) * 46'(LCG_MULT);
        end
        if (cmd.calc_idx || cmd.draw_commit) begin
            idx_q_reg <= idx_prod[62:SHIFT];
        end
        if (cmd.draw_commit) begin
            sample_reg <= (table_rdata > SAMPLE_MAX) ? SAMPLE_MAX : table_rdata;
        end
    end

    // Shuffle table: filled during a reseed, swapped on each draw.
    assign table_we    = cmd.seed_we || cmd.draw_commit;
    assign table_waddr = cmd.draw_commit ? idx : seed_addr;

    slcg_ram #(
        .WIDTH(31),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (table_we),
        .waddr(table_waddr),
        .wdata(fold_x),
        .raddr(idx),
        .rdata(table_rdata)
    );

    assign seeded   = (last_reg != 31'd0);
    assign m_sample = sample_reg;

endmodule

/* hw/rtl/slcg_ctrl.sv */
// Controller of the shuffled Lehmer generator: sequences reseed, table fill
// and draws, and owns the input ready and the result valid.
// Depends on slcg_pkg.
module slcg_ctrl #(
    parameter int TABLE_DEPTH = slcg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_op,
    output logic                           s_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           seeded,
    output slcg_pkg::slcg_cmd_t            cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] seed_addr
);
    import slcg_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int STEPS = WARMUP_STEPS + TABLE_DEPTH;
    localparam int CW = $clog2(STEPS);
    localparam logic [CW-1:0] CNT_LAST = CW'(STEPS - 1);
    localparam logic [CW-1:0] CNT_FILL = CW'(WARMUP_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_FOLD,
        ST_SEED_IDX,
        ST_DRAW_MUL,
        ST_DRAW_FOLD
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic          out_free;
    logic [CW-1:0] fill_offset;

    assign out_free = !m_valid_reg || m_ready;

    // The table fills from the highest entry down after the warm-up steps.
    assign fill_offset = CNT_LAST - cnt_reg;
    assign seed_addr   = fill_offset[AW-1:0];

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_RESEED) begin
                        cmd.load_seed      = 1'b1;
                        cmd.seed_sel_input = 1'b1;
                        cnt_next           = '0;
                        state_next         = ST_SEED_MUL;
                    end else if (!seeded) begin
                        cmd.load_seed = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_SEED_MUL;
                    end else begin
                        cmd.mul    = 1'b1;
                        state_next = ST_DRAW_FOLD;
                    end
                end
            end
            ST_SEED_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SEED_FOLD;
            end
            ST_SEED_FOLD: begin
                cmd.fold    = 1'b1;
                cmd.seed_we = (cnt_reg >= CNT_FILL);
                if (cnt_reg == CNT_LAST) begin
                    cmd.seed_last = 1'b1;
                    state_next    = ST_SEED_IDX;
                end else begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_SEED_MUL;
                end
            end
            ST_SEED_IDX: begin
                cmd.calc_idx = 1'b1;
                state_next   = ST_DRAW_MUL;
            end
            ST_DRAW_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DRAW_FOLD;
            end
            ST_DRAW_FOLD: begin
                if (out_free) begin
                    cmd.fold        = 1'b1;
                    cmd.draw_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.draw_commit || (m_valid_reg && !m_ready);

    // State, step counter and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // A draw completes only when the result register can take the word.
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw_commit |-> (!m_valid_reg || m_ready))
        else $error("draw committed over an unread result");

    // A draw never reads the table before it was filled.
    a_commit_seeded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw_commit |-> seeded)
        else $error("draw committed while unseeded");

    // A reseed word starts the seeding sequence.
    a_reseed_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_RESEED) |=>
            (state_reg == ST_SEED_MUL && cnt_reg == '0))
        else $error("reseed did not start the seeding sequence");

    // Fill writes stay inside the table.
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.seed_we |-> (32'(seed_addr) < 32'(TABLE_DEPTH)))
        else $error("fill address past the table");

    // A new result word appears only after a committed draw.
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.draw_commit))
        else $error("result valid without a draw");

endmodule

/* hw/rtl/shuffled_lcg_uniform_rng_top.sv */
// Shuffled Lehmer uniform generator: x = 16807 * x mod (2^31 - 1) feeding
// a shuffle table of TABLE_DEPTH entries.
// Input channel (s_): one word per request. s_op = 0 draws the next number,
// s_op = 1 reseeds from s_seed_value (zero or 2^31 - 1 become one) and draws.
// A draw before any seed seeds itself from the generator first.
// Result channel (m_): one word per request, m_sample in 1..2147483389,
// read as a fraction by dividing by 2147483647.
// A plain draw registers the multiply in the accepting cycle, then runs the
// modular fold; m_valid rises at the edge that ends the fold.
// A reseeding word loads the seed in the accepting cycle, then runs eight
// warm-up steps and one step per table entry, each a multiply and a fold,
// then the index setup and the draw.
// s_ready is high whenever no word is in progress; a finished result sits in
// an output register, so the next word is taken while that result waits.
// If the receiver stalls, the following draw holds in its last cycle until
// the output register frees up; nothing is lost or repeated.
// Reset (synchronous, active low) sets the generator to one and marks the
// block unseeded; the table contents are left as they are.
// Depends on slcg_pkg, slcg_ctrl, slcg_dpath and slcg_ram.
module shuffled_lcg_uniform_rng_top #(
    parameter int TABLE_DEPTH = slcg_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [30:0] s_seed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_sample
);
    import slcg_pkg::*;

    slcg_cmd_t                      cmd;
    logic                           seeded;
    logic [$clog2(TABLE_DEPTH)-1:0] seed_addr;

    // Sequencer.
    slcg_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_op     (s_op),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .seeded   (seeded),
        .cmd      (cmd),
        .seed_addr(seed_addr)
    );

    // Arithmetic, table and result register.
    slcg_dpath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .seed_addr   (seed_addr),
        .s_seed_value(s_seed_value),
        .seeded      (seeded),
        .m_sample    (m_sample)
    );

endmodule
